@@ src/esc_pkg.sv @@
`default_nettype none

package esc_pkg;

  localparam int unsigned WordWidthDef  = 24;
  localparam int unsigned FracBitsDef   = 8;
  localparam int unsigned RadiusWidth   = 10;
  localparam int unsigned RadiusReset   = 30;
  localparam int unsigned ContactFactor = 4;
  localparam int unsigned ContactShift  = $clog2(ContactFactor);
  localparam int unsigned OutcomeWidth  = 2;

  typedef enum logic [OutcomeWidth-1:0] {
    OUT_APART    = 2'd0,
    OUT_SEPARATE = 2'd1,
    OUT_IMPULSE  = 2'd2
  } outcome_e;

endpackage

`default_nettype wire

@@ src/esc_if.sv @@
`default_nettype none

interface esc_in_if #(
  parameter int unsigned WordWidth = esc_pkg::WordWidthDef
) ();
  logic                        valid;
  logic                        ready;
  logic signed [WordWidth-1:0] pos_a_x;
  logic signed [WordWidth-1:0] pos_a_y;
  logic signed [WordWidth-1:0] pos_a_z;
  logic signed [WordWidth-1:0] pos_b_x;
  logic signed [WordWidth-1:0] pos_b_y;
  logic signed [WordWidth-1:0] pos_b_z;
  logic signed [WordWidth-1:0] vel_a_x;
  logic signed [WordWidth-1:0] vel_a_y;
  logic signed [WordWidth-1:0] vel_a_z;
  logic signed [WordWidth-1:0] vel_b_x;
  logic signed [WordWidth-1:0] vel_b_y;
  logic signed [WordWidth-1:0] vel_b_z;

  modport source (
    output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
           vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
    input  ready
  );
  modport sink (
    input  valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
           vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
    output ready
  );
endinterface

interface esc_out_if #(
  parameter int unsigned WordWidth = esc_pkg::WordWidthDef
) ();
  logic                                 valid;
  logic                                 ready;
  logic signed [WordWidth-1:0]          new_vel_a_x;
  logic signed [WordWidth-1:0]          new_vel_a_y;
  logic signed [WordWidth-1:0]          new_vel_a_z;
  logic signed [WordWidth-1:0]          new_vel_b_x;
  logic signed [WordWidth-1:0]          new_vel_b_y;
  logic signed [WordWidth-1:0]          new_vel_b_z;
  logic [esc_pkg::OutcomeWidth-1:0]     outcome;

  modport source (
    output valid, new_vel_a_x, new_vel_a_y, new_vel_a_z,
           new_vel_b_x, new_vel_b_y, new_vel_b_z, outcome,
    input  ready
  );
  modport sink (
    input  valid, new_vel_a_x, new_vel_a_y, new_vel_a_z,
           new_vel_b_x, new_vel_b_y, new_vel_b_z, outcome,
    output ready
  );
endinterface

`default_nettype wire

@@ src/elastic_sphere_collision_response.sv @@
// channel   | dir | handshake       | payload
// in_i      | in  | valid / ready   | pos_a/b xyz, vel_a/b xyz
// out_o     | out | valid / ready   | new_vel_a/b xyz, outcome
// cfg       | in  | cfg_we_i        | cfg_wdata_i = sphere_radius
//
// one item per cycle unless out_o.ready holds the pipeline back; a
// restoring divider works out one quotient bit per stage
// every stage has its own valid bit; a stage loads when empty or when the
// stage after it moves, so bubbles close up and in_i.ready stays high
// while any stage is empty, even with a result waiting at out_o
// reset clears the valid bits and sets the radius to 30

`default_nettype none

module elastic_sphere_collision_response #(
  parameter int unsigned WORD_WIDTH = esc_pkg::WordWidthDef,
  parameter int unsigned FRAC_BITS  = esc_pkg::FracBitsDef
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  esc_in_if.sink                          in_i,
  esc_out_if.source                       out_o,
  input  wire                             cfg_we_i,
  input  wire [esc_pkg::RadiusWidth-1:0]  cfg_wdata_i
);

  localparam int unsigned W    = WORD_WIDTH;
  localparam int unsigned DW   = W + 1;
  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned SW   = PW + 1;
  localparam int unsigned MW   = PW;
  localparam int unsigned QW   = W + 1;
  localparam int unsigned NW   = PW + DW;
  localparam int unsigned RW   = esc_pkg::RadiusWidth;
  localparam int unsigned BSH  = esc_pkg::ContactShift + 2 * FRAC_BITS;
  localparam int unsigned BW   = 2 * RW + BSH;
  localparam int unsigned CW   = (BW > MW) ? BW : MW;
  localparam int unsigned DIV0 = 6;
  localparam int unsigned NS   = QW + 7;

  typedef struct packed {
    logic [2:0][W-1:0]  va;
    logic [2:0][W-1:0]  vb;
    logic [2:0]         ineg;
    esc_pkg::outcome_e  oc;
  } carry_t;

  function automatic logic [W-1:0] sat(input logic signed [W+2:0] v);
    logic [3:0] top;
    top = v[W+2:W-1];
    if ((&top) || !(|top)) begin
      sat = v[W-1:0];
    end else if (v[W+2]) begin
      sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  // config and contact bound
  logic [RW-1:0]   radius_q;
  logic [2*RW-1:0] rsq;
  logic [BW-1:0]   bound_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RW'(esc_pkg::RadiusReset);
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  assign rsq = radius_q * radius_q;

  always_ff @(posedge clk_i) begin
    bound_q <= {rsq, {BSH{1'b0}}};
  end

  // valid and load chain
  logic [NS-1:0] v_q;
  logic [NS:0]   ld;

  assign ld[NS] = out_o.ready;
  for (genvar g = 0; g < NS; g++) begin : g_ld
    assign ld[g] = !v_q[g] || ld[g+1];
  end
  assign in_i.ready = ld[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 1: differences
  logic [2:0][W-1:0]      pa, pb;
  logic signed [DW-1:0]   dl_d [3];
  logic signed [DW-1:0]   vr_d [3];
  carry_t                 c1_d;
  logic signed [DW-1:0]   dl_q [3];
  logic signed [DW-1:0]   vr_q [3];
  carry_t                 c1_q;

  assign pa = {in_i.pos_a_z, in_i.pos_a_y, in_i.pos_a_x};
  assign pb = {in_i.pos_b_z, in_i.pos_b_y, in_i.pos_b_x};

  always_comb begin
    c1_d.va   = {in_i.vel_a_z, in_i.vel_a_y, in_i.vel_a_x};
    c1_d.vb   = {in_i.vel_b_z, in_i.vel_b_y, in_i.vel_b_x};
    c1_d.ineg = '0;
    c1_d.oc   = esc_pkg::OUT_APART;
    for (int i = 0; i < 3; i++) begin
      dl_d[i] = $signed({pb[i][W-1], pb[i]}) - $signed({pa[i][W-1], pa[i]});
      vr_d[i] = $signed({c1_d.vb[i][W-1], c1_d.vb[i]})
              - $signed({c1_d.va[i][W-1], c1_d.va[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      dl_q <= dl_d;
      vr_q <= vr_d;
      c1_q <= c1_d;
    end
  end

  // stage 2: products
  logic signed [PW-1:0] sq_d [3];
  logic signed [PW-1:0] pr_d [3];
  logic [DW-1:0]        dm_d [3];
  logic signed [PW-1:0] sq_q [3];
  logic signed [PW-1:0] pr_q [3];
  logic [DW-1:0]        dm2_q [3];
  logic [2:0]           dn2_q;
  carry_t               c2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = dl_q[i] * dl_q[i];
      pr_d[i] = dl_q[i] * vr_q[i];
      dm_d[i] = dl_q[i][DW-1] ? $unsigned(-dl_q[i]) : $unsigned(dl_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      sq_q  <= sq_d;
      pr_q  <= pr_d;
      dm2_q <= dm_d;
      dn2_q <= {dl_q[2][DW-1], dl_q[1][DW-1], dl_q[0][DW-1]};
      c2_q  <= c1_q;
    end
  end

  // stage 3: squared distance and dot product
  logic signed [SW-1:0] dsum, psum;
  logic [MW-1:0]        dist3_q;
  logic signed [SW-1:0] dot3_q;
  logic [DW-1:0]        dm3_q [3];
  logic [2:0]           dn3_q;
  carry_t               c3_q;

  assign dsum = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
  assign psum = SW'(pr_q[0]) + SW'(pr_q[1]) + SW'(pr_q[2]);

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      dist3_q <= dsum[MW-1:0];
      dot3_q  <= psum;
      dm3_q   <= dm2_q;
      dn3_q   <= dn2_q;
      c3_q    <= c2_q;
    end
  end

  // stage 4: contact test and outcome
  logic                 close, dneg, dzero;
  logic signed [SW-1:0] dotm;
  carry_t               c4_d;
  logic [MW-1:0]        dist4_q;
  logic [MW-1:0]        dotm4_q;
  logic [DW-1:0]        dm4_q [3];
  carry_t               c4_q;

  always_comb begin
    close = (CW'(dist3_q) <= CW'(bound_q)) && (dist3_q != '0);
    dneg  = dot3_q[SW-1];
    dzero = (dot3_q == '0);
    dotm  = dneg ? -dot3_q : dot3_q;
    c4_d  = c3_q;
    c4_d.ineg = dn3_q ^ {3{dneg}};
    if (!close) begin
      c4_d.oc = esc_pkg::OUT_APART;
    end else if (!dneg && !dzero) begin
      c4_d.oc = esc_pkg::OUT_SEPARATE;
    end else begin
      c4_d.oc = esc_pkg::OUT_IMPULSE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      dist4_q <= dist3_q;
      dotm4_q <= dotm[MW-1:0];
      dm4_q   <= dm3_q;
      c4_q    <= c4_d;
    end
  end

  // stage 5: partial products of |dot| * |delta|
  logic [PW-1:0] plo_q [3];
  logic [PW-1:0] phi_q [3];
  logic [MW-1:0] dist5_q;
  carry_t        c5_q;

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      for (int i = 0; i < 3; i++) begin
        plo_q[i] <= dotm4_q[DW-1:0] * dm4_q[i];
        phi_q[i] <= dotm4_q[MW-1:DW] * dm4_q[i];
      end
      dist5_q <= dist4_q;
      c5_q    <= c4_q;
    end
  end

  // stage 6: numerators
  logic [NW-1:0] num6_q [3];
  logic [MW-1:0] dist6_q;
  carry_t        c6_q;

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      for (int i = 0; i < 3; i++) begin
        num6_q[i] <= NW'(plo_q[i]) + (NW'(phi_q[i]) << DW);
      end
      dist6_q <= dist5_q;
      c6_q    <= c5_q;
    end
  end

  // restoring divider, one quotient bit per stage
  logic [NW-1:0] rem_q [QW][3];
  logic [QW-1:0] quo_q [QW][3];
  logic [MW-1:0] dd_q  [QW];
  carry_t        cd_q  [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [NW-1:0] rin [3];
    logic [QW-1:0] qin [3];
    logic [MW-1:0] din;
    carry_t        cin;
    logic [NW-1:0] sh;
    logic [NW:0]   diff [3];

    if (j == 0) begin : g_first
      assign rin = num6_q;
      assign qin = '{default: '0};
      assign din = dist6_q;
      assign cin = c6_q;
    end else begin : g_next
      assign rin = rem_q[j-1];
      assign qin = quo_q[j-1];
      assign din = dd_q[j-1];
      assign cin = cd_q[j-1];
    end

    assign sh = NW'(din) << (QW - 1 - j);

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        diff[i] = {1'b0, rin[i]} - {1'b0, sh};
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[DIV0+j]) begin
        for (int i = 0; i < 3; i++) begin
          rem_q[j][i] <= diff[i][NW] ? rin[i] : diff[i][NW-1:0];
          quo_q[j][i] <= {qin[i][QW-2:0], !diff[i][NW]};
        end
        dd_q[j] <= din;
        cd_q[j] <= cin;
      end
    end
  end

  // output stage: apply impulse and saturate
  carry_t                cl;
  logic signed [W+1:0]   imp [3];
  logic [2:0][W-1:0]     nva_d, nvb_d;
  logic [2:0][W-1:0]     nva_q, nvb_q;
  esc_pkg::outcome_e     oc_q;

  assign cl = cd_q[QW-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cl.oc != esc_pkg::OUT_IMPULSE) begin
        imp[i] = '0;
      end else if (cl.ineg[i]) begin
        imp[i] = -$signed({1'b0, quo_q[QW-1][i]});
      end else begin
        imp[i] = $signed({1'b0, quo_q[QW-1][i]});
      end
      nva_d[i] = sat($signed({{3{cl.va[i][W-1]}}, cl.va[i]}) + (W+3)'(imp[i]));
      nvb_d[i] = sat($signed({{3{cl.vb[i][W-1]}}, cl.vb[i]}) - (W+3)'(imp[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[NS-1]) begin
      nva_q <= nva_d;
      nvb_q <= nvb_d;
      oc_q  <= cl.oc;
    end
  end

  assign out_o.valid       = v_q[NS-1];
  assign out_o.new_vel_a_x = nva_q[0];
  assign out_o.new_vel_a_y = nva_q[1];
  assign out_o.new_vel_a_z = nva_q[2];
  assign out_o.new_vel_b_x = nvb_q[0];
  assign out_o.new_vel_b_y = nvb_q[1];
  assign out_o.new_vel_b_z = nvb_q[2];
  assign out_o.outcome     = oc_q;

  // any empty stage lets a new item in
  a_ready_on_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(v_q) < NS) |-> in_i.ready)
    else $error("input stalled with an empty stage");

  // coincident centres never take the impulse path
  a_zero_dist_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld[3] && v_q[2] && dist3_q == '0) |=> (c4_q.oc == esc_pkg::OUT_APART))
    else $error("zero distance not reported apart");

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NS-2] && cl.oc == esc_pkg::OUT_IMPULSE) |->
      (rem_q[QW-1][0] < NW'(dd_q[QW-1]) && rem_q[QW-1][1] < NW'(dd_q[QW-1])
       && rem_q[QW-1][2] < NW'(dd_q[QW-1])))
    else $error("division remainder out of range");

endmodule

`default_nettype wire

@@ tb/sv/tb_elastic_sphere_collision_response.sv @@
`timescale 1ns / 1ps

module tb_elastic_sphere_collision_response;

  localparam int W = esc_pkg::WordWidthDef;
  localparam int F = esc_pkg::FracBitsDef;
  localparam int LATENCY = W + 8;
  localparam int STALL_LIMIT = 5000;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct {
    logic signed [W-1:0] pa[3];
    logic signed [W-1:0] pb[3];
    logic signed [W-1:0] va[3];
    logic signed [W-1:0] vb[3];
  } pair_t;

  typedef struct {
    logic signed [W-1:0] nva[3];
    logic signed [W-1:0] nvb[3];
    esc_pkg::outcome_e   outcome;
  } bounce_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [esc_pkg::RadiusWidth-1:0] cfg_wdata = '0;

  esc_in_if  in_if ();
  esc_out_if out_if ();

  elastic_sphere_collision_response i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  pair_t   pending_q[$];
  bounce_t bounce_q[$];
  int unsigned radius = esc_pkg::RadiusReset;
  int mismatches = 0;
  int n_in = 0, n_out = 0, n_impulse = 0, n_separate = 0, n_apart = 0;
  int stall_cnt = 0;
  bit steady_in = 0, steady_out = 0;
  int in_gap = 0, out_gap = 0;

  function automatic logic signed [W-1:0] clamp_word(longint v);
    if (v > longint'(WMAX)) return WMAX;
    if (v < longint'(WMIN)) return WMIN;
    return v[W-1:0];
  endfunction

  function automatic bounce_t resolve_contact(pair_t p, int unsigned r);
    bounce_t     res;
    longint      d[3], vrel, dsq, dot, bound, imp[3];
    logic [127:0] dmag, num, q;
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'(p.pb[i]) - longint'(p.pa[i]);
      imp[i] = 0;
    end
    dsq = 0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      vrel = longint'(p.vb[i]) - longint'(p.va[i]);
      dsq += d[i] * d[i];
      dot += vrel * d[i];
    end
    bound = (longint'(esc_pkg::ContactFactor) * r * r) <<< (2 * F);
    if (dsq > bound || dsq == 0) begin
      res.outcome = esc_pkg::OUT_APART;
    end else if (dot > 0) begin
      res.outcome = esc_pkg::OUT_SEPARATE;
    end else begin
      res.outcome = esc_pkg::OUT_IMPULSE;
      dmag = 128'(-dot);
      for (int i = 0; i < 3; i++) begin
        num = dmag * 128'(d[i] < 0 ? -d[i] : d[i]);
        q = num / 128'(dsq);
        imp[i] = (d[i] < 0) ? longint'(q[63:0]) : -longint'(q[63:0]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      res.nva[i] = clamp_word(longint'(p.va[i]) + imp[i]);
      res.nvb[i] = clamp_word(longint'(p.vb[i]) - imp[i]);
    end
    return res;
  endfunction

  function automatic int pick_gap(bit steady);
    int c;
    if (steady) return 0;
    c = $urandom_range(0, 99);
    if (c < 55) return 0;
    if (c < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    pair_t p;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        p.pa = '{in_if.pos_a_x, in_if.pos_a_y, in_if.pos_a_z};
        p.pb = '{in_if.pos_b_x, in_if.pos_b_y, in_if.pos_b_z};
        p.va = '{in_if.vel_a_x, in_if.vel_a_y, in_if.vel_a_z};
        p.vb = '{in_if.vel_b_x, in_if.vel_b_y, in_if.vel_b_z};
        bounce_q.push_back(resolve_contact(p, radius));
        n_in++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          p = pending_q.pop_front();
          in_if.pos_a_x <= p.pa[0];
          in_if.pos_a_y <= p.pa[1];
          in_if.pos_a_z <= p.pa[2];
          in_if.pos_b_x <= p.pb[0];
          in_if.pos_b_y <= p.pb[1];
          in_if.pos_b_z <= p.pb[2];
          in_if.vel_a_x <= p.va[0];
          in_if.vel_a_y <= p.va[1];
          in_if.vel_a_z <= p.va[2];
          in_if.vel_b_x <= p.vb[0];
          in_if.vel_b_y <= p.vb[1];
          in_if.vel_b_z <= p.vb[2];
          in_if.valid <= 1'b1;
          in_gap = pick_gap(steady_in);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    bounce_t e;
    logic signed [W-1:0] got_a[3], got_b[3];
    bit bad;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
      if (out_if.valid && out_if.ready) begin
        n_out++;
        got_a = '{out_if.new_vel_a_x, out_if.new_vel_a_y, out_if.new_vel_a_z};
        got_b = '{out_if.new_vel_b_x, out_if.new_vel_b_y, out_if.new_vel_b_z};
        if (bounce_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %0d", n_out);
        end else begin
          e = bounce_q.pop_front();
          bad = (out_if.outcome != e.outcome);
          for (int i = 0; i < 3; i++)
            if (got_a[i] != e.nva[i] || got_b[i] != e.nvb[i]) bad = 1;
          case (e.outcome)
            esc_pkg::OUT_IMPULSE:  n_impulse++;
            esc_pkg::OUT_SEPARATE: n_separate++;
            default:               n_apart++;
          endcase
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch item %0d: exp a=%0d,%0d,%0d b=%0d,%0d,%0d %s",
                        " got a=%0d,%0d,%0d b=%0d,%0d,%0d %0d"},
                       n_out, e.nva[0], e.nva[1], e.nva[2], e.nvb[0], e.nvb[1], e.nvb[2],
                       e.outcome.name(), got_a[0], got_a[1], got_a[2], got_b[0], got_b[1],
                       got_b[2], out_if.outcome);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        out_gap = pick_gap(steady_out);
      end
    end
  end

  function automatic logic signed [W-1:0] rand_word();
    return W'($urandom);
  endfunction

  function automatic pair_t make_pair(logic signed [W-1:0] pa[3], logic signed [W-1:0] pb[3],
                                      logic signed [W-1:0] va[3], logic signed [W-1:0] vb[3]);
    pair_t p;
    p.pa = pa;
    p.pb = pb;
    p.va = va;
    p.vb = vb;
    return p;
  endfunction

  function automatic pair_t rand_pair(int unsigned r);
    pair_t p;
    int    lim, mode;
    mode = $urandom_range(0, 9);
    lim = 2 * r * (1 << F) + 16;
    if ($urandom_range(0, 1)) lim = lim / 2 + 1;
    for (int i = 0; i < 3; i++) begin
      if (mode < 2) begin
        p.pa[i] = rand_word();
        p.pb[i] = rand_word();
      end else begin
        p.pa[i] = ($urandom_range(0, 3) == 0) ? rand_word()
                : W'($signed($urandom_range(0, 8191)) - 4096);
        p.pb[i] = p.pa[i] + W'($signed($urandom_range(0, 2 * lim)) - lim);
        if (mode == 2 && $urandom_range(0, 1)) p.pb[i] = p.pa[i];
      end
      if (mode < 2 || $urandom_range(0, 9) < 3) begin
        p.va[i] = rand_word();
        p.vb[i] = rand_word();
      end else begin
        p.va[i] = W'($signed($urandom_range(0, 131071)) - 65536);
        p.vb[i] = W'($signed($urandom_range(0, 131071)) - 65536);
      end
    end
    return p;
  endfunction

  task automatic queue_directed(int unsigned r);
    logic signed [W-1:0] z[3], t[3];
    int edge_pos;
    edge_pos = 2 * r * (1 << F);
    z = '{0, 0, 0};
    pending_q.push_back(make_pair(z, z, z, z));
    pending_q.push_back(make_pair(z, z, '{5, -7, 9}, '{-3, 2, 1}));
    pending_q.push_back(make_pair('{WMAX, WMAX, WMAX}, '{WMAX, WMAX, WMAX},
                                  '{WMAX, WMAX, WMAX}, '{WMAX, WMAX, WMAX}));
    pending_q.push_back(make_pair('{WMIN, WMIN, WMIN}, '{WMAX, WMAX, WMAX},
                                  '{WMIN, WMIN, WMIN}, '{WMAX, WMAX, WMAX}));
    pending_q.push_back(make_pair('{WMAX, WMIN, WMAX}, '{WMIN, WMAX, WMIN},
                                  '{WMAX, WMIN, 0}, '{WMIN, WMAX, 0}));
    t = '{W'(edge_pos), 0, 0};
    pending_q.push_back(make_pair(z, t, '{256, 0, 0}, z));
    t = '{W'(edge_pos + 1), 0, 0};
    pending_q.push_back(make_pair(z, t, '{256, 0, 0}, z));
    t = '{0, W'(-edge_pos), 0};
    pending_q.push_back(make_pair(z, t, z, '{0, 300, 0}));
    t = '{W'(r * 100), W'(r * 60), 0};
    pending_q.push_back(make_pair(z, t, '{-256, 0, 0}, z));
    pending_q.push_back(make_pair(z, t, '{5, 5, 5}, '{5, 5, 5}));
    pending_q.push_back(make_pair(z, t, '{3, 0, 0}, '{0, 3, 0}));
    t = '{W'(r), W'(r), 0};
    pending_q.push_back(make_pair(z, t, '{0, W'(24'h700000), 0}, '{WMIN, WMAX, 0}));
    t = '{W'(-r), W'(-r), 0};
    pending_q.push_back(make_pair(z, t, '{0, W'(-24'sh700000), 0}, '{WMAX, WMIN, 0}));
    t = '{W'(r), W'(-r), W'(r)};
    pending_q.push_back(make_pair(z, t, '{WMAX, WMIN, WMAX}, '{WMIN, WMAX, WMIN}));
    pending_q.push_back(make_pair('{1, 1, 1}, '{2, 2, 2},
                                  '{W'(1000), 0, 0}, '{W'(-1000), 0, 0}));
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || bounce_q.size() > 0 || in_if.valid) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic set_radius(int unsigned r);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= esc_pkg::RadiusWidth'(r);
    radius = r;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned radii[6];
    in_if.valid = 1'b0;
    {in_if.pos_a_x, in_if.pos_a_y, in_if.pos_a_z} = '0;
    {in_if.pos_b_x, in_if.pos_b_y, in_if.pos_b_z} = '0;
    {in_if.vel_a_x, in_if.vel_a_y, in_if.vel_a_z} = '0;
    {in_if.vel_b_x, in_if.vel_b_y, in_if.vel_b_z} = '0;
    out_if.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    radii = '{esc_pkg::RadiusReset, 1023, 1, 0, $urandom_range(2, 1022),
              esc_pkg::RadiusReset};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) set_radius(radii[ph]);
      steady_in = ($urandom_range(0, 3) == 0);
      steady_out = ($urandom_range(0, 3) == 0);
      if (ph == 0 || ph == 1 || ph == 3) queue_directed(radii[ph]);
      for (int k = 0; k < 290; k++) pending_q.push_back(rand_pair(radii[ph]));
      drain();
    end

    $display("%0d pairs in, %0d out over six radius settings (0, 1, 1023 among them)",
             n_in, n_out);
    $display("impulse %0d, separating %0d, apart %0d, mismatches %0d",
             n_impulse, n_separate, n_apart, mismatches);
    if (mismatches == 0 && bounce_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
